// ----- rtl/sobel_rgb_gradient_magnitude_top_assert.svh -----
// ----------------------------------------------------------------------------
// sobel rgb gradient magnitude assertion macros
// concurrent checks on the top level, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef SOBEL_RGB_GRADIENT_MAGNITUDE_TOP_ASSERT_SVH
`define SOBEL_RGB_GRADIENT_MAGNITUDE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define SOBRGB_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sobrgb assertion failed");
// condition never holds
`define SOBRGB_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("sobrgb assertion failed");
`else
`define SOBRGB_ASSERT_IMPLIES(lbl, ante, cons)
`define SOBRGB_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/sobrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// sobrgb_pkg
// shared types and constants of the rgb sobel gradient magnitude block
// ----------------------------------------------------------------------------
`default_nettype none
package sobrgb_pkg;

   // default frame limits
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // csr port
   localparam int CFG_WIDTH       = 11;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT = 1'b1;
   localparam logic [CFG_WIDTH-1:0] IMAGE_SIZE_RESET = 11'd1024;

   // request opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int CH_WIDTH  = 8;
   localparam int PIX_WIDTH = 3 * CH_WIDTH;

   // window queue depth
   localparam int QUEUE_DEPTH = 2;

   // magnitude arithmetic
   localparam int          ROOT_BITS   = 19;
   localparam int          RAD_WIDTH   = 2 * ROOT_BITS;
   localparam int          REM_WIDTH   = 24;
   localparam int          SS_WIDTH    = 21;
   localparam int          SUM_WIDTH   = 18;
   localparam logic [18:0] MAG_CLAMP   = 19'd65280;
   localparam logic [9:0]  RECIP_THIRD = 10'd683;

   typedef struct packed {
      logic                opcode;
      logic [CH_WIDTH-1:0] channel_zero;
      logic [CH_WIDTH-1:0] channel_one;
      logic [CH_WIDTH-1:0] channel_two;
   } req_type;

   typedef struct packed {
      logic [7:0] gradient_gray;
      logic       frame_end;
   } rsp_type;

   // mirrored 3x3 window, [row][column]
   typedef struct packed {
      logic [2:0][2:0][PIX_WIDTH-1:0] pix;
      logic                           last;
   } win_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

// ----- rtl/sobel_rgb_gradient_magnitude_top.sv -----
// Streaming 3x3 Sobel gradient magnitude on BGR pixels in raster order, giving one gray
// value per pixel: the truncated mean of the three clamped channel magnitudes. The result
// for a pixel comes with the request image_width+1 requests later; drain requests
// (opcode 1) push out the tail of the frame and frame_end marks its last result. In the
// front part a request goes through a line store read, then a window shift and write. In
// the back part the square root unit is shared by the three channels and yields one bit
// per cycle; a two-entry window queue lets the front keep taking requests meanwhile. The
// line stores are one RAM of MAX_WIDTH entries and need no clearing pass after reset. The
// user must see that sizes are written on the csr port only while the block is idle; the
// block does not enforce this. Sizes are clamped to [2, MAX].
`default_nettype none
module sobel_rgb_gradient_magnitude_top #(
   parameter int MAX_WIDTH  = sobrgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sobrgb_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire sobrgb_pkg::req_type                    req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output sobrgb_pkg::rsp_type                         rsp_data,
   input  wire logic                                   csr_we,
   input  wire logic [sobrgb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sobrgb_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import sobrgb_pkg::*;
`include "sobel_rgb_gradient_magnitude_top_assert.svh"

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CFG_WIDTH-1:0] image_width_ff, image_width_in;
   logic [CFG_WIDTH-1:0] image_height_ff, image_height_in;
   logic [WW-1:0]        img_w;
   logic [HW-1:0]        img_h;
   logic                 push, pop;
   win_item_type         push_item, head_item;
   queue_status_type     q_stat;

   // size registers
   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: image_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_SIZE_RESET;
         image_height_ff <= IMAGE_SIZE_RESET;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
      end
   end

   // clamp sizes to the supported range
   always_comb begin
      if (32'(image_width_ff) < 32'd2) img_w = WW'(2);
      else if (32'(image_width_ff) > 32'(MAX_WIDTH)) img_w = WW'(MAX_WIDTH);
      else img_w = WW'(image_width_ff);
      if (32'(image_height_ff) < 32'd2) img_h = HW'(2);
      else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) img_h = HW'(MAX_HEIGHT);
      else img_h = HW'(image_height_ff);
   end

   sobrgb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .img_w     (img_w),
      .img_h     (img_h),
      .q_stat    (q_stat),
      .push      (push),
      .push_item (push_item)
   );

   sobrgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   sobrgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_item (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // queue is never overrun or read empty
   `SOBRGB_ASSERT_NEVER(a_no_push_full, push && q_stat.full)
   `SOBRGB_ASSERT_IMPLIES(a_pop_nonempty, pop, !q_stat.empty)
   // a window is only pushed while the front takes no new request
   `SOBRGB_ASSERT_IMPLIES(a_push_when_idle_front, push, !req_ready)

endmodule
`default_nettype wire

// ----- rtl/sobrgb_ram.sv -----
// ----------------------------------------------------------------------------
// sobrgb_ram
// simple dual port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module sobrgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/sobrgb_front.sv -----
// ----------------------------------------------------------------------------
// sobrgb_front
// request intake, line stores, window shift, border mirroring
// ----------------------------------------------------------------------------
`default_nettype none
module sobrgb_front #(
   parameter int MAX_WIDTH  = sobrgb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = sobrgb_pkg::MAX_HEIGHT_DEF,
   localparam int WW = $clog2(MAX_WIDTH + 1),
   localparam int HW = $clog2(MAX_HEIGHT + 1)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire sobrgb_pkg::req_type          req_data,
   input  wire logic [WW-1:0]                img_w,
   input  wire logic [HW-1:0]                img_h,
   input  wire sobrgb_pkg::queue_status_type q_stat,
   output logic                              push,
   output sobrgb_pkg::win_item_type          push_item
);
   import sobrgb_pkg::*;

   localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW = $clog2(MAX_HEIGHT + 2);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_PUSH = 2'b10
   } front_state_type;

   front_state_type                state_ff, state_in;
   logic [XW-1:0]                  col_ff, col_in;
   logic [YW-1:0]                  row_ff, row_in;
   logic [PIX_WIDTH-1:0]           px_ff, px_in;
   logic [2:0][2:0][PIX_WIDTH-1:0] win_ff, win_in;

   logic                           take, in_rows, drop, rd_en, wr_en, commit, has_out, last;
   logic [2*PIX_WIDTH-1:0]         line_rd;
   logic [PIX_WIDTH-1:0]           old_v, new_v;
   logic [2:0][2:0][PIX_WIDTH-1:0] shift_win, mir_win;
   logic [WW-1:0]                  col_w, ocol;
   logic [YW-1:0]                  orow, h_y;

   // both previous rows in one word: older above, newer below
   sobrgb_ram #(
      .WIDTH (2 * PIX_WIDTH),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (col_ff),
      .wr_data ({new_v, px_ff}),
      .rd_en   (rd_en),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign old_v = line_rd[2*PIX_WIDTH-1:PIX_WIDTH];
   assign new_v = line_rd[PIX_WIDTH-1:0];

   // intake
   assign req_ready = (state_ff == F_IDLE);
   assign take      = req_valid && req_ready;
   assign h_y       = YW'(img_h);
   assign in_rows   = (row_ff < h_y);
   assign drop      = in_rows && (req_data.opcode == OP_DRAIN);
   assign rd_en     = take && !drop;

   // window shift and output position
   always_comb begin
      shift_win = win_ff;
      for (int a = 0; a < 3; a++) begin
         shift_win[a][0] = win_ff[a][1];
         shift_win[a][1] = win_ff[a][2];
      end
      shift_win[0][2] = old_v;
      shift_win[1][2] = new_v;
      shift_win[2][2] = px_ff;

      col_w   = WW'(col_ff);
      has_out = (row_ff >= YW'(2)) || ((row_ff == YW'(1)) && (col_ff != '0));
      if (col_ff != '0) begin
         ocol = col_w - WW'(1);
         orow = row_ff - YW'(1);
      end else begin
         ocol = img_w - WW'(1);
         orow = row_ff - YW'(2);
      end
      last = (orow >= h_y - YW'(1)) && (ocol >= img_w - WW'(1));

      // mirror borders without repeating the edge
      mir_win = shift_win;
      for (int a = 0; a < 3; a++) begin
         if (ocol == '0) mir_win[a][0] = mir_win[a][2];
         if (ocol >= img_w - WW'(1)) mir_win[a][2] = mir_win[a][0];
      end
      for (int a = 0; a < 3; a++) begin
         if (orow == '0) mir_win[0][a] = mir_win[2][a];
         if (orow >= h_y - YW'(1)) mir_win[2][a] = mir_win[0][a];
      end
   end

   assign commit         = (state_ff == F_PUSH) && !(has_out && q_stat.full);
   assign push           = (state_ff == F_PUSH) && has_out && !q_stat.full;
   assign wr_en          = commit;
   assign push_item.pix  = mir_win;
   assign push_item.last = last;

   // next state
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      px_in    = px_ff;
      win_in   = win_ff;
      case (state_ff)
         F_IDLE: begin
            if (rd_en) begin
               px_in    = in_rows ? {req_data.channel_two, req_data.channel_one,
                                     req_data.channel_zero} : '0;
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (commit) begin
               win_in = shift_win;
               if (col_w + WW'(1) >= img_w) begin
                  col_in = '0;
                  row_in = row_ff + YW'(1);
               end else begin
                  col_in = col_ff + XW'(1);
               end
               if (has_out && last) begin
                  col_in = '0;
                  row_in = '0;
               end
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         win_ff   <= win_in;
      end
      px_ff <= px_in;
   end

endmodule
`default_nettype wire

// ----- rtl/sobrgb_queue.sv -----
// ----------------------------------------------------------------------------
// sobrgb_queue
// short register queue of mirrored windows between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module sobrgb_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire sobrgb_pkg::win_item_type     push_item,
   input  wire logic                         pop,
   output sobrgb_pkg::win_item_type          head_item,
   output sobrgb_pkg::queue_status_type      q_stat
);
   import sobrgb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   win_item_type  entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head_item    = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) count_in = count_ff + CW'(1);
      if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/sobrgb_back.sv -----
// ----------------------------------------------------------------------------
// sobrgb_back
// per channel sobel gradients, iterative square root, mean of channels
// ----------------------------------------------------------------------------
`default_nettype none
module sobrgb_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sobrgb_pkg::queue_status_type q_stat,
   input  wire sobrgb_pkg::win_item_type     head_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output sobrgb_pkg::rsp_type               rsp_data
);
   import sobrgb_pkg::*;

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_GRAD = 7'b0000010,
      B_SQ   = 7'b0000100,
      B_ROOT = 7'b0001000,
      B_ACC  = 7'b0010000,
      B_DIV  = 7'b0100000,
      B_OUT  = 7'b1000000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic [2:0][2:0][PIX_WIDTH-1:0] win_ff, win_in;
   logic                           last_ff, last_in;
   logic [1:0]                     ch_ff, ch_in;
   logic [9:0]                     ax_ff, ax_in, ay_ff, ay_in;
   logic [RAD_WIDTH-1:0]           rad_ff, rad_in;
   logic [REM_WIDTH-1:0]           rem_ff, rem_in;
   logic [ROOT_BITS-1:0]           root_ff, root_in;
   logic [4:0]                     step_ff, step_in;
   logic [SUM_WIDTH-1:0]           sum_ff, sum_in;
   logic [19:0]                    prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_type                        rsp_ff, rsp_in;

   logic [2:0][2:0][CH_WIDTH-1:0]  p;
   logic signed [11:0]             gx, gy;
   logic [SS_WIDTH-1:0]            ss;
   logic [REM_WIDTH-1:0]           cur, trial;
   logic [ROOT_BITS-1:0]           mag;

   // one channel of the window
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            p[a][b] = win_ff[a][b][ch_ff*CH_WIDTH +: CH_WIDTH];
         end
      end
      gx = (12'(p[0][2]) + (12'(p[1][2]) << 1) + 12'(p[2][2]))
         - (12'(p[0][0]) + (12'(p[1][0]) << 1) + 12'(p[2][0]));
      gy = (12'(p[2][0]) + (12'(p[2][1]) << 1) + 12'(p[2][2]))
         - (12'(p[0][0]) + (12'(p[0][1]) << 1) + 12'(p[0][2]));
   end

   // sum of squares, one root digit, clamp
   assign ss    = SS_WIDTH'(ax_ff * ax_ff) + SS_WIDTH'(ay_ff * ay_ff);
   assign cur   = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1 -: 2]};
   assign trial = {3'b000, root_ff, 2'b01};
   assign mag   = (root_ff > MAG_CLAMP) ? MAG_CLAMP : root_ff;

   assign pop       = (state_ff == B_IDLE) && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      ch_in        = ch_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         B_IDLE: begin
            if (pop) begin
               win_in   = head_item.pix;
               last_in  = head_item.last;
               ch_in    = '0;
               sum_in   = '0;
               state_in = B_GRAD;
            end
         end
         B_GRAD: begin
            ax_in    = gx[11] ? 10'(-gx) : 10'(gx);
            ay_in    = gy[11] ? 10'(-gy) : 10'(gy);
            state_in = B_SQ;
         end
         B_SQ: begin
            rad_in   = {1'b0, ss, 16'h0000};
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            // restoring square root, one result bit per cycle
            if (cur >= trial) begin
               rem_in  = cur - trial;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = cur;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(ROOT_BITS - 1)) state_in = B_ACC;
         end
         B_ACC: begin
            sum_in = sum_ff + SUM_WIDTH'(mag);
            if (ch_ff == 2'd2) begin
               state_in = B_DIV;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = B_GRAD;
            end
         end
         B_DIV: begin
            // divide by 768: drop 8 bits, then times 683 over 2048
            prod_in  = sum_ff[SUM_WIDTH-1:8] * RECIP_THIRD;
            state_in = B_OUT;
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.gradient_gray = prod_ff[18:11];
               rsp_in.frame_end     = last_ff;
               state_in             = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff  <= win_in;
      last_ff <= last_in;
      ch_ff   <= ch_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire
